// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rfr_pkg.sv =====
`default_nettype none

package rfr_pkg;

  localparam logic [7:0] HDR0       = 8'hFA;
  localparam logic [7:0] HDR1       = 8'hFB;
  localparam logic [7:0] FUNC_LIMIT = 8'hF1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CKSUM = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;
  localparam logic [1:0] STATUS_CLIP  = 2'd3;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_TARGET  = 1'b1;

  localparam int unsigned TARGET_BYTES = 6;
  localparam logic [2:0]  FETCH_LAST   = 3'(TARGET_BYTES - 1);

  typedef struct packed {
    logic sum_init;
    logic sum_add;
    logic func_load;
    logic len_load;
    logic pay_store;
    logic sum_out;
    logic rd_capture;
    logic tgt_out;
  } rfr_cmd_t;

  typedef struct packed {
    logic is_hdr0;
    logic is_hdr1;
    logic func_ok;
    logic len_ok;
    logic len_zero;
    logic rem_one;
    logic sum_last;
    logic fetch_last;
    logic tgt_last;
  } rfr_sts_t;

endpackage

`default_nettype wire

// ===== src/rfr_ram.sv =====
`default_nettype none

module rfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 49
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rfr_ctrl.sv =====
`default_nettype none

module rfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rfr_pkg::rfr_sts_t sts,
  output rfr_pkg::rfr_cmd_t      cmd
);

  import rfr_pkg::*;

  typedef enum logic [3:0] {
    S_HUNT,
    S_HDR1,
    S_FUNC,
    S_LEN,
    S_PAY,
    S_CHECK,
    S_ADDR,
    S_DATA,
    S_WAIT
  } state_t;

  state_t state;
  logic   in_acc;
  logic   out_free;

  always_comb begin
    in_ready = (state inside {S_HUNT, S_HDR1, S_FUNC, S_LEN, S_PAY}) ||
               (state == S_CHECK && !out_valid);
    in_acc   = in_valid && in_ready;
    out_free = !out_valid || out_ready;

    cmd.sum_init   = in_acc && state == S_HUNT && sts.is_hdr0;
    cmd.sum_add    = in_acc && ((state == S_HDR1 && sts.is_hdr1) ||
                                (state == S_FUNC && sts.func_ok) ||
                                (state == S_LEN && sts.len_ok) ||
                                state == S_PAY);
    cmd.func_load  = in_acc && state == S_FUNC && sts.func_ok;
    cmd.len_load   = in_acc && state == S_LEN && sts.len_ok;
    cmd.pay_store  = in_acc && state == S_PAY;
    cmd.sum_out    = in_acc && state == S_CHECK;
    cmd.rd_capture = state == S_DATA;
    cmd.tgt_out    = state == S_WAIT && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_HUNT;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sum_out || cmd.tgt_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_HUNT: begin
          if (in_acc && sts.is_hdr0) begin
            state <= S_HDR1;
          end
        end
        S_HDR1: begin
          if (in_acc) begin
            state <= sts.is_hdr1 ? S_FUNC : S_HUNT;
          end
        end
        S_FUNC: begin
          if (in_acc) begin
            state <= sts.func_ok ? S_LEN : S_HUNT;
          end
        end
        S_LEN: begin
          if (in_acc) begin
            if (!sts.len_ok) begin
              state <= S_HUNT;
            end else begin
              state <= sts.len_zero ? S_CHECK : S_PAY;
            end
          end
        end
        S_PAY: begin
          if (in_acc && sts.rem_one) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (in_acc) begin
            state <= sts.sum_last ? S_HUNT : S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_DATA;
        end
        S_DATA: begin
          state <= sts.fetch_last ? S_WAIT : S_ADDR;
        end
        S_WAIT: begin
          if (out_free) begin
            state <= sts.tgt_last ? S_HUNT : S_ADDR;
          end
        end
        default: begin
          state <= S_HUNT;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_summary_raises_valid, clk, rst, cmd.sum_out, out_valid, "summary not presented")
  `ASSERT_ALWAYS(a_load_into_free_reg, clk, rst, cmd.sum_out || cmd.tgt_out, !out_valid || out_ready, "result overwritten before transaction")
  `ASSERT_ALWAYS(a_no_input_while_fetching, clk, rst, state == S_ADDR || state == S_DATA || state == S_WAIT, !in_ready, "input taken during target fetch")

endmodule

`default_nettype wire

// ===== src/rfr_datapath.sv =====
`default_nettype none

module rfr_datapath #(
  parameter int MAX_PAYLOAD = 49,
  parameter int MAX_TARGETS = 7
) (
  input  wire logic              clk,
  input  wire logic [7:0]        rx_byte,
  input  wire rfr_pkg::rfr_cmd_t cmd,
  output rfr_pkg::rfr_sts_t      sts,
  output logic                   record_kind,
  output logic [1:0]             status,
  output logic [7:0]             function_code,
  output logic                   hold_release,
  output logic signed [7:0]      height_delta,
  output logic [7:0]             target_count,
  output logic [2:0]             target_index,
  output logic [15:0]            distance,
  output logic [31:0]            level,
  output logic                   last
);

  import rfr_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = $clog2(MAX_PAYLOAD);
  localparam int AV_W   = $clog2(MAX_PAYLOAD / TARGET_BYTES + 1);
  localparam int EMIT_W = $clog2(MAX_TARGETS + 1);

  logic [7:0]        running_sum;
  logic [7:0]        func_byte;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  remaining;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        height_byte;
  logic [7:0]        count_byte;
  logic [2:0]        grp_pos;
  logic [AV_W-1:0]   avail;
  logic [EMIT_W-1:0] emit_reg;
  logic [EMIT_W-1:0] tgt_idx;
  logic [2:0]        fetch_cnt;
  logic [47:0]       target_bytes;
  logic [7:0]        rd_data;

  logic              chk_err;
  logic              func_zero;
  logic              short_pay;
  logic [7:0]        emit_a;
  logic [7:0]        emit_b;
  logic [1:0]        sum_status;
  logic [7:0]        sum_height;
  logic [7:0]        sum_count;

  rfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload_ram (
    .clk  (clk),
    .we   (cmd.pay_store),
    .waddr(wr_addr),
    .wdata(rx_byte),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    chk_err   = running_sum != rx_byte;
    func_zero = func_byte == 8'd0;
    short_pay = frame_len < LEN_W'(2);
    emit_a    = (count_byte < 8'(avail)) ? count_byte : 8'(avail);
    emit_b    = (emit_a < 8'(MAX_TARGETS)) ? emit_a : 8'(MAX_TARGETS);

    sum_height = 8'd0;
    sum_count  = 8'd0;
    if (chk_err) begin
      sum_status = STATUS_CKSUM;
    end else if (func_zero) begin
      sum_status = STATUS_OK;
    end else if (short_pay) begin
      sum_status = STATUS_SHORT;
      sum_height = (frame_len != '0) ? height_byte : 8'd0;
    end else begin
      sum_status = (emit_b < count_byte) ? STATUS_CLIP : STATUS_OK;
      sum_height = height_byte;
      sum_count  = count_byte;
    end

    sts.is_hdr0    = rx_byte == HDR0;
    sts.is_hdr1    = rx_byte == HDR1;
    sts.func_ok    = rx_byte < FUNC_LIMIT;
    sts.len_ok     = rx_byte <= 8'(MAX_PAYLOAD);
    sts.len_zero   = rx_byte == 8'd0;
    sts.rem_one    = remaining == LEN_W'(1);
    sts.sum_last   = chk_err || func_zero || short_pay || emit_b == 8'd0;
    sts.fetch_last = fetch_cnt == FETCH_LAST;
    sts.tgt_last   = tgt_idx == emit_reg - EMIT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      running_sum <= rx_byte;
    end else if (cmd.sum_add) begin
      running_sum <= running_sum + rx_byte;
    end

    if (cmd.func_load) begin
      func_byte <= rx_byte;
    end

    if (cmd.len_load) begin
      frame_len <= LEN_W'(rx_byte);
      remaining <= LEN_W'(rx_byte);
      wr_addr   <= '0;
      grp_pos   <= 3'd0;
      avail     <= '0;
    end else if (cmd.pay_store) begin
      wr_addr   <= wr_addr + ADDR_W'(1);
      remaining <= remaining - LEN_W'(1);
      if (wr_addr == '0) begin
        height_byte <= rx_byte;
      end
      if (wr_addr == ADDR_W'(1)) begin
        count_byte <= rx_byte;
      end
      if (wr_addr >= ADDR_W'(2)) begin
        if (grp_pos == FETCH_LAST) begin
          grp_pos <= 3'd0;
          avail   <= avail + AV_W'(1);
        end else begin
          grp_pos <= grp_pos + 3'd1;
        end
      end
    end

    if (cmd.sum_out) begin
      record_kind   <= KIND_SUMMARY;
      status        <= sum_status;
      function_code <= func_byte;
      hold_release  <= !chk_err && func_zero;
      height_delta  <= sum_height;
      target_count  <= sum_count;
      target_index  <= 3'd0;
      distance      <= 16'd0;
      level         <= 32'd0;
      last          <= sts.sum_last;
      emit_reg      <= EMIT_W'(emit_b);
      tgt_idx       <= '0;
      rd_addr       <= ADDR_W'(2);
      fetch_cnt     <= 3'd0;
    end else if (cmd.rd_capture) begin
      target_bytes <= {target_bytes[39:0], rd_data};
      rd_addr      <= rd_addr + ADDR_W'(1);
      fetch_cnt    <= fetch_cnt + 3'd1;
    end else if (cmd.tgt_out) begin
      record_kind   <= KIND_TARGET;
      status        <= STATUS_OK;
      function_code <= func_byte;
      hold_release  <= 1'b0;
      height_delta  <= 8'sd0;
      target_count  <= 8'd0;
      target_index  <= 3'(tgt_idx);
      distance      <= target_bytes[47:32];
      level         <= target_bytes[31:0];
      last          <= sts.tgt_last;
      tgt_idx       <= tgt_idx + EMIT_W'(1);
      fetch_cnt     <= 3'd0;
    end
  end

endmodule

`default_nettype wire

// ===== src/radar_frame_receiver.sv =====
// Header, function, length and payload bytes are taken one per cycle with no result.
// The checksum byte puts the frame summary in the output register on the next cycle.
// Each target record then takes six payload RAM reads, each an address state and a data state,
// and a wait state that loads the output register once it is free.
// A frame end holds the input while its target records are fetched and loaded, stalls included.
// Synchronous rst returns the parser to hunting and empties the output; the RAM is not cleared.
`default_nettype none

module radar_frame_receiver #(
  parameter int MAX_PAYLOAD = 49,
  parameter int MAX_TARGETS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             record_kind,
  output logic [1:0]       status,
  output logic [7:0]       function_code,
  output logic             hold_release,
  output logic signed [7:0] height_delta,
  output logic [7:0]       target_count,
  output logic [2:0]       target_index,
  output logic [15:0]      distance,
  output logic [31:0]      level,
  output logic             last
);

  import rfr_pkg::*;

  rfr_cmd_t cmd;
  rfr_sts_t sts;

  rfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfr_datapath #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .MAX_TARGETS(MAX_TARGETS)
  ) u_datapath (
    .clk          (clk),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .record_kind  (record_kind),
    .status       (status),
    .function_code(function_code),
    .hold_release (hold_release),
    .height_delta (height_delta),
    .target_count (target_count),
    .target_index (target_index),
    .distance     (distance),
    .level        (level),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== sim/radar_frame_checker.sv =====
`timescale 1ns / 100ps

module radar_frame_checker #(
  parameter int MAX_PAYLOAD = 49,
  parameter int MAX_TARGETS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        record_kind,
  input  logic [1:0]  status,
  input  logic [7:0]  function_code,
  input  logic        hold_release,
  input  logic [7:0]  height_delta,
  input  logic [7:0]  target_count,
  input  logic [2:0]  target_index,
  input  logic [15:0] distance,
  input  logic [31:0] level,
  input  logic        last,
  output int          fail_count,
  output int          expected_left,
  output int          records_checked
);

  import rfr_pkg::*;

  typedef enum logic [2:0] {
    HUNT_HDR0,
    WAIT_HDR1,
    WAIT_FUNC,
    WAIT_LEN,
    TAKE_PAYLOAD,
    WAIT_CKSUM
  } parse_state_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  func;
    logic        hold;
    logic [7:0]  height;
    logic [7:0]  count;
    logic [2:0]  index;
    logic [15:0] dist_val;
    logic [31:0] lvl;
    logic        last;
  } frame_record_t;

  parse_state_t  parse_state = HUNT_HDR0;
  logic [7:0]    frame_func = '0;
  logic [7:0]    frame_sum = '0;
  int            frame_len;
  int            bytes_left;
  int            bytes_kept;
  logic [7:0]    payload_bytes [MAX_PAYLOAD];
  frame_record_t pending_records [$];

  task automatic report_mismatch(input string msg);
    if (fail_count < 30) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted) begin
      report_mismatch($sformatf("record %0d field %s is %0h, expected %0h",
                                records_checked, name, seen, wanted));
    end
  endtask

  task automatic close_frame(input logic [7:0] check);
    frame_record_t rec;
    int            avail;
    int            emit;
    int            base;
    logic [7:0]    sent;
    rec = '0;
    rec.kind = KIND_SUMMARY;
    rec.func = frame_func;
    rec.last = 1'b1;
    if (frame_sum != check) begin
      rec.status = STATUS_CKSUM;
      pending_records.push_back(rec);
    end else if (frame_func == 8'd0) begin
      rec.hold = 1'b1;
      pending_records.push_back(rec);
    end else if (frame_len < 2) begin
      rec.status = STATUS_SHORT;
      rec.height = (frame_len >= 1) ? payload_bytes[0] : 8'd0;
      pending_records.push_back(rec);
    end else begin
      sent = payload_bytes[1];
      avail = (frame_len - 2) / TARGET_BYTES;
      emit = sent;
      if (emit > avail) emit = avail;
      if (emit > MAX_TARGETS) emit = MAX_TARGETS;
      rec.status = (emit < sent) ? STATUS_CLIP : STATUS_OK;
      rec.height = payload_bytes[0];
      rec.count = sent;
      rec.last = (emit == 0);
      pending_records.push_back(rec);
      for (int i = 0; i < emit; i++) begin
        base = 2 + TARGET_BYTES * i;
        rec = '0;
        rec.kind = KIND_TARGET;
        rec.func = frame_func;
        rec.index = 3'(i);
        rec.dist_val = {payload_bytes[base], payload_bytes[base + 1]};
        rec.lvl = {payload_bytes[base + 2], payload_bytes[base + 3],
                   payload_bytes[base + 4], payload_bytes[base + 5]};
        rec.last = (i + 1 == emit);
        pending_records.push_back(rec);
      end
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    case (parse_state)
      WAIT_HDR1: begin
        if (b == HDR1) begin
          frame_sum = frame_sum + b;
          parse_state = WAIT_FUNC;
        end else begin
          parse_state = HUNT_HDR0;
        end
      end
      WAIT_FUNC: begin
        if (b < FUNC_LIMIT) begin
          frame_func = b;
          frame_sum = frame_sum + b;
          parse_state = WAIT_LEN;
        end else begin
          parse_state = HUNT_HDR0;
        end
      end
      WAIT_LEN: begin
        if (b <= MAX_PAYLOAD) begin
          frame_sum = frame_sum + b;
          frame_len = b;
          bytes_left = b;
          bytes_kept = 0;
          parse_state = (b == 8'd0) ? WAIT_CKSUM : TAKE_PAYLOAD;
        end else begin
          parse_state = HUNT_HDR0;
        end
      end
      TAKE_PAYLOAD: begin
        if (bytes_kept < MAX_PAYLOAD) payload_bytes[bytes_kept] = b;
        bytes_kept++;
        frame_sum = frame_sum + b;
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) parse_state = WAIT_CKSUM;
      end
      WAIT_CKSUM: begin
        parse_state = HUNT_HDR0;
        close_frame(b);
      end
      default: begin
        if (b == HDR0) begin
          frame_sum = b;
          parse_state = WAIT_HDR1;
        end else begin
          parse_state = HUNT_HDR0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    frame_record_t got;
    frame_record_t want;
    if (rst) begin
      parse_state = HUNT_HDR0;
      frame_func = '0;
      frame_sum = '0;
      frame_len = 0;
      bytes_left = 0;
      bytes_kept = 0;
      pending_records.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{record_kind, status, function_code, hold_release, height_delta,
                target_count, target_index, distance, level, last};
        records_checked++;
        if (pending_records.size() == 0) begin
          report_mismatch($sformatf("record %0d arrived with nothing expected",
                                    records_checked));
        end else begin
          want = pending_records.pop_front();
          check_field("record_kind", got.kind, want.kind);
          check_field("status", got.status, want.status);
          check_field("function_code", got.func, want.func);
          check_field("hold_release", got.hold, want.hold);
          check_field("height_delta", got.height, want.height);
          check_field("target_count", got.count, want.count);
          check_field("target_index", got.index, want.index);
          check_field("distance", got.dist_val, want.dist_val);
          check_field("level", got.lvl, want.lvl);
          check_field("last", got.last, want.last);
        end
      end
      if (in_valid && in_ready) begin
        parse_rx_byte(rx_byte);
      end
    end
    expected_left = pending_records.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  import rfr_pkg::*;

  localparam int PAYLOAD_MAX = 49;
  localparam int TARGETS_MAX = 7;
  localparam int BYTE_GOAL = 210;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        in_ready;
  logic        out_valid;
  logic        record_kind;
  logic [1:0]  status;
  logic [7:0]  function_code;
  logic        hold_release;
  logic signed [7:0] height_delta;
  logic [7:0]  target_count;
  logic [2:0]  target_index;
  logic [15:0] distance;
  logic [31:0] level;
  logic        last;

  int fail_count;
  int expected_left;
  int records_checked;
  int gap_pct = 0;
  int stall_pct = 0;
  int frame_bytes = 0;
  int frames_sent = 0;
  int cycle_count = 0;

  radar_frame_receiver #(
    .MAX_PAYLOAD(PAYLOAD_MAX),
    .MAX_TARGETS(TARGETS_MAX)
  ) dut (.*);

  radar_frame_checker #(
    .MAX_PAYLOAD(PAYLOAD_MAX),
    .MAX_TARGETS(TARGETS_MAX)
  ) frame_check (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // A negative head or count leaves that payload byte random.
  task automatic send_frame(input logic [7:0] fn, input int len, input int head,
                            input int cnt, input bit bad_sum);
    logic [7:0] csum;
    logic [7:0] b;
    csum = HDR0 + HDR1 + fn + 8'(len);
    put_byte(HDR0);
    put_byte(HDR1);
    put_byte(fn);
    put_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0 && head >= 0) b = 8'(head);
      if (i == 1 && cnt >= 0) b = 8'(cnt);
      csum = csum + b;
      put_byte(b);
    end
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
    put_byte(csum);
    frames_sent++;
    frame_bytes += len + 5;
  endtask

  task automatic send_broken();
    int         cut;
    logic [7:0] b;
    cut = $urandom_range(2);
    put_byte(HDR0);
    if (cut == 0) begin
      b = 8'($urandom);
      if (b == HDR1) b = 8'd0;
      put_byte(b);
      frame_bytes += 2;
    end else begin
      put_byte(HDR1);
      if (cut == 1) begin
        put_byte(8'($urandom_range(FUNC_LIMIT, 255)));
        frame_bytes += 3;
      end else begin
        put_byte(8'($urandom_range(0, FUNC_LIMIT - 1)));
        put_byte(8'($urandom_range(PAYLOAD_MAX + 1, 255)));
        frame_bytes += 4;
      end
    end
  endtask

  task automatic send_random_frame();
    logic [7:0] fn;
    int         len;
    int         cnt;
    int         pick;
    int         room;
    pick = $urandom_range(99);
    if (pick < 15) fn = 8'd0;
    else if (pick < 20) fn = FUNC_LIMIT - 1;
    else fn = 8'($urandom_range(1, FUNC_LIMIT - 1));
    pick = $urandom_range(99);
    if (frames_sent % 8 == 7) len = PAYLOAD_MAX;
    else if (pick < 20) len = $urandom_range(0, 1);
    else len = $urandom_range(2, 14);
    cnt = -1;
    if (len >= 2) begin
      room = (len - 2) / TARGET_BYTES;
      if (room > TARGETS_MAX) room = TARGETS_MAX;
      pick = $urandom_range(99);
      if (pick < 60) cnt = $urandom_range(0, room);
      else if (pick < 80) cnt = $urandom_range(0, TARGETS_MAX + 1);
    end
    send_frame(fn, len, -1, cnt, $urandom_range(99) < 10);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int gaps [4];
    int stalls [4];
    int pick;
    logic [7:0] b;
    gaps = '{0, 47, 0, 31};
    stalls = '{0, 0, 47, 31};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(8'h00, 0, -1, -1, 1'b0);
    send_frame(FUNC_LIMIT - 1, 1, 8'h80, -1, 1'b0);
    send_frame(8'h05, 0, -1, -1, 1'b1);
    put_byte(HDR0);
    put_byte(8'h11);
    put_byte(HDR0);
    put_byte(HDR0);
    put_byte(HDR1);
    put_byte(HDR0);
    put_byte(HDR1);
    put_byte(FUNC_LIMIT);
    put_byte(HDR0);
    put_byte(HDR1);
    put_byte(8'h07);
    put_byte(8'(PAYLOAD_MAX + 1));
    send_frame(8'h01, 8, 8'h7F, 2, 1'b0);

    for (int p = 0; p < 4; p++) begin
      drain_results();
      gap_pct = gaps[p];
      stall_pct <= stalls[p];
      while (frame_bytes < BYTE_GOAL * (p + 1) / 4) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom);
            if (b == HDR0) b = 8'h05;
            put_byte(b);
          end
        end else if (pick < 16) begin
          send_broken();
        end else begin
          send_random_frame();
        end
      end
    end
    drain_results();
    repeat (120) @(posedge clk);

    $display("Drove %0d frame bytes in %0d frames over four flow-control mixes.",
             frame_bytes, frames_sent);
    $display("Compared %0d output records against the parser prediction.",
             records_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
